@@ rtl/core/scof_pkg.sv @@
// Shared types and constants for the sigma-clip outlier filter.
// No dependencies; imported by every module in rtl/core.
package scof_pkg;

  localparam int unsigned MAX_ITEMS        = 64;
  localparam int unsigned SMALL_LIST_LIMIT = 3;
  localparam int unsigned RESULT_CAP       = 63;
  localparam int unsigned DEV_SHIFT        = 6;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned LIM_W  = 7;
  localparam int unsigned CLIP_W = 16;
  localparam int unsigned SUM_W  = 38;
  localparam int unsigned NUM_W  = 41;
  localparam int unsigned DEN_W  = 8;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned PROD_W = 2 * MAG_W;
  localparam int unsigned TOT_W  = 64;
  localparam int unsigned RHS_W  = 96;

  localparam logic [CLIP_W-1:0] CLIP_RESET = 16'd25035;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_WAIT,
    ST_P1_RD,
    ST_P1_SQ,
    ST_P1_ACC,
    ST_R_KK,
    ST_R_LO,
    ST_R_HI,
    ST_R_SUM,
    ST_P2_RD,
    ST_P2_SQ,
    ST_P2_ML,
    ST_P2_MH,
    ST_P2_CMP,
    ST_E_CHK,
    ST_E_SCAN,
    ST_E_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

@@ rtl/core/scof_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on scof_pkg for the control struct.
module scof_div #(
  parameter int unsigned NumW = 41,
  parameter int unsigned DenW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NumW-1:0]      dividend_i,
  input  logic [DenW-1:0]      divisor_i,
  output logic [NumW-1:0]      quotient_o,
  output scof_pkg::div_ctrl_t  ctrl_o
);
  import scof_pkg::*;

  localparam int unsigned CW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
      cnt_d = CW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o   = quo_q;
  assign ctrl_o.start = start_i;
  assign ctrl_o.done  = done_q;

endmodule

@@ rtl/core/scof_mul.sv @@
// Shared 33x33 unsigned multiplier with registered product.
// Depends on scof_pkg for operand widths.
module scof_mul (
  input  logic                          clk_i,
  input  logic [scof_pkg::MAG_W-1:0]    a_i,
  input  logic [scof_pkg::MAG_W-1:0]    b_i,
  output logic [scof_pkg::PROD_W-1:0]   prod_o
);
  import scof_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/core/sigma_clip_outlier_filter_core.sv @@
// Sigma-clip outlier filter top: sample store, sequencer, shared multiplier, divider.
// Depends on scof_pkg, scof_div and scof_mul. Load: one word per cycle while busy_o is low.
// On the last word: N <= 3 goes straight to output; longer lists take a mean and variance
// pass and a test pass, paced by the serial divider and the one shared multiplier, then
// emit kept words. Results strobe one cycle each; no stall.
// Reset clears counters and control state and loads clip_factor with 25035.
module sigma_clip_outlier_filter_core #(
  parameter int unsigned MaxItems       = scof_pkg::MAX_ITEMS,
  parameter int unsigned SmallListLimit = scof_pkg::SMALL_LIST_LIMIT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [scof_pkg::VAL_W-1:0]    sample_value_i,
  input  logic                          end_of_list_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scof_pkg::CLIP_W-1:0]   cfg_data_i,
  output logic                          result_valid_o,
  output logic [scof_pkg::VAL_W-1:0]    kept_value_o,
  output logic [scof_pkg::POS_W-1:0]    kept_position_o,
  output logic                          final_result_o,
  output logic                          none_valid_o,
  output logic                          overflowed_o
);
  import scof_pkg::*;

  localparam int unsigned IdxW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  state_e state_q, state_d;

  logic [VAL_W-1:0]  sample_mem [MaxItems];
  logic [VAL_W-1:0]  rd_q;

  logic [CntW-1:0]   count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              ovf_q, ovf_d;
  logic [CLIP_W-1:0] clip_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [VAL_W-1:0]  mean_q, mean_d;
  logic              neg_q, neg_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [31:0]       kk_q, kk_d;
  logic [TOT_W-1:0]  p0_q, p0_d;
  logic [RHS_W-1:0]  rhs_q, rhs_d;
  logic [25:0]       thi_q, thi_d;
  logic [TOT_W-1:0]  lo_q, lo_d;
  logic [MaxItems-1:0] flags_q, flags_d;
  logic [LIM_W-1:0]  passes_q, passes_d;
  logic [LIM_W-1:0]  emit_q, emit_d;

  logic              res_v_q, res_v_d, res_fin_q, res_fin_d, res_none_q, res_none_d;
  logic              res_ovf_q, res_ovf_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;

  logic              accept, last_idx, keep;
  logic [MAG_W-1:0]  mul_a, mul_b, mag;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  dev;
  logic [57:0]       term;
  logic [TOT_W-1:0]  lhs;
  logic [MAG_W-1:0]  nm1;
  logic [LIM_W-1:0]  limit;
  logic              cap_hit;
  logic [39:0]       num;
  logic [39:0]       num_mag;
  logic [NUM_W-1:0]  dividend;
  logic [DEN_W-1:0]  divisor;
  logic [NUM_W-1:0]  quotient;
  div_ctrl_t         div_ctrl;
  logic              div_start;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;

  assign last_idx = (CntW'(idx_q) == count_q - 1'b1);
  assign dev      = {rd_q[VAL_W-1], rd_q} - {mean_q[VAL_W-1], mean_q};
  assign mag      = dev[MAG_W-1] ? MAG_W'(-dev) : dev;
  assign term     = prod[63:DEV_SHIFT];
  assign nm1      = MAG_W'(count_q - 1'b1);
  assign lhs      = {prod[31:0], 32'd0} + lo_q;
  assign keep     = (lhs < rhs_q[95:32]) || ((lhs == rhs_q[95:32]) && (rhs_q[31:0] != '0));
  assign cap_hit  = (passes_q > LIM_W'(RESULT_CAP));
  assign limit    = cap_hit ? LIM_W'(RESULT_CAP) : passes_q;

  assign num      = {sum_q[SUM_W-1], sum_q, 1'b0} + 40'(count_q);
  assign num_mag  = num[39] ? 40'(-num) : num;
  assign divisor  = DEN_W'(count_q) << 1;
  assign dividend = NUM_W'(num_mag) + (num[39] ? NUM_W'(divisor - 1'b1) : '0);

  scof_div #(
    .NumW (NUM_W),
    .DenW (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .ctrl_o     (div_ctrl)
  );

  scof_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept && end_of_list_i) state_d = ST_PREP;
      ST_PREP:     state_d = (count_q <= CntW'(SmallListLimit)) ? ST_E_CHK : ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_ctrl.done) state_d = ST_P1_RD;
      ST_P1_RD:    state_d = ST_P1_SQ;
      ST_P1_SQ:    state_d = ST_P1_ACC;
      ST_P1_ACC:   state_d = last_idx ? ST_R_KK : ST_P1_RD;
      ST_R_KK:     state_d = ST_R_LO;
      ST_R_LO:     state_d = ST_R_HI;
      ST_R_HI:     state_d = ST_R_SUM;
      ST_R_SUM:    state_d = ST_P2_RD;
      ST_P2_RD:    state_d = ST_P2_SQ;
      ST_P2_SQ:    state_d = ST_P2_ML;
      ST_P2_ML:    state_d = ST_P2_MH;
      ST_P2_MH:    state_d = ST_P2_CMP;
      ST_P2_CMP:   state_d = last_idx ? ST_E_CHK : ST_P2_RD;
      ST_E_CHK:    state_d = (passes_q == '0) ? ST_IDLE : ST_E_SCAN;
      ST_E_SCAN:   if (flags_q[idx_q]) state_d = ST_E_OUT;
      ST_E_OUT:    state_d = (emit_q + 1'b1 == limit) ? ST_IDLE : ST_E_SCAN;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    mean_d     = mean_q;
    neg_d      = neg_q;
    total_d    = total_q;
    kk_d       = kk_q;
    p0_d       = p0_q;
    rhs_d      = rhs_q;
    thi_d      = thi_q;
    lo_d       = lo_q;
    flags_d    = flags_q;
    passes_d   = passes_q;
    emit_d     = emit_q;
    res_v_d    = 1'b0;
    res_val_d  = res_val_q;
    res_pos_d  = res_pos_q;
    res_fin_d  = res_fin_q;
    res_none_d = res_none_q;
    res_ovf_d  = res_ovf_q;
    mul_a      = mag;
    mul_b      = mag;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < CntW'(MaxItems)) begin
            count_d = count_q + 1'b1;
            sum_d   = sum_q + {{(SUM_W-VAL_W){sample_value_i[VAL_W-1]}}, sample_value_i};
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_PREP: begin
        idx_d   = '0;
        emit_d  = '0;
        total_d = '0;
        if (count_q <= CntW'(SmallListLimit)) begin
          flags_d  = '1;
          passes_d = LIM_W'(count_q);
        end else begin
          neg_d     = num[39];
          div_start = 1'b1;
          flags_d   = '0;
          passes_d  = '0;
        end
      end
      ST_DIV_WAIT: begin
        if (div_ctrl.done) begin
          mean_d = neg_q ? VAL_W'(-quotient) : quotient[VAL_W-1:0];
        end
      end
      ST_P1_ACC: begin
        total_d = total_q + TOT_W'(term);
        idx_d   = last_idx ? '0 : idx_q + 1'b1;
      end
      ST_R_KK: begin
        mul_a = MAG_W'(clip_q);
        mul_b = MAG_W'(clip_q);
      end
      ST_R_LO: begin
        kk_d  = prod[31:0];
        mul_a = MAG_W'(prod[31:0]);
        mul_b = MAG_W'(total_q[31:0]);
      end
      ST_R_HI: begin
        p0_d  = prod[63:0];
        mul_a = MAG_W'(kk_q);
        mul_b = MAG_W'(total_q[63:32]);
      end
      ST_R_SUM: begin
        rhs_d = RHS_W'(p0_q) + {prod[63:0], 32'd0};
      end
      ST_P2_ML: begin
        thi_d = term[57:32];
        mul_a = MAG_W'(term[31:0]);
        mul_b = nm1;
      end
      ST_P2_MH: begin
        lo_d  = prod[63:0];
        mul_a = MAG_W'(thi_q);
        mul_b = nm1;
      end
      ST_P2_CMP: begin
        flags_d[idx_q] = keep;
        passes_d       = passes_q + LIM_W'(keep);
        idx_d          = last_idx ? '0 : idx_q + 1'b1;
      end
      ST_E_CHK: begin
        if (passes_q == '0) begin
          res_v_d    = 1'b1;
          res_val_d  = '0;
          res_pos_d  = '0;
          res_fin_d  = 1'b1;
          res_none_d = 1'b1;
          res_ovf_d  = ovf_q;
          count_d    = '0;
          sum_d      = '0;
          ovf_d      = 1'b0;
        end
      end
      ST_E_SCAN: begin
        if (!flags_q[idx_q]) idx_d = idx_q + 1'b1;
      end
      ST_E_OUT: begin
        res_v_d    = 1'b1;
        res_val_d  = rd_q;
        res_pos_d  = POS_W'(idx_q);
        res_fin_d  = (emit_q + 1'b1 == limit);
        res_none_d = 1'b0;
        res_ovf_d  = ovf_q || cap_hit;
        emit_d     = emit_q + 1'b1;
        idx_d      = idx_q + 1'b1;
        if (emit_q + 1'b1 == limit) begin
          count_d = '0;
          sum_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && (count_q < CntW'(MaxItems))) begin
      sample_mem[IdxW'(count_q)] <= sample_value_i;
    end
    rd_q <= sample_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      sum_q    <= '0;
      ovf_q    <= 1'b0;
      clip_q   <= CLIP_RESET;
      mean_q   <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      passes_q <= '0;
      emit_q   <= '0;
      flags_q  <= '0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      ovf_q    <= ovf_d;
      mean_q   <= mean_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      passes_q <= passes_d;
      emit_q   <= emit_d;
      flags_q  <= flags_d;
      res_v_q  <= res_v_d;
      if (cfg_valid_i && cfg_ready_o) clip_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    kk_q       <= kk_d;
    p0_q       <= p0_d;
    rhs_q      <= rhs_d;
    thi_q      <= thi_d;
    lo_q       <= lo_d;
    res_val_q  <= res_val_d;
    res_pos_q  <= res_pos_d;
    res_fin_q  <= res_fin_d;
    res_none_q <= res_none_d;
    res_ovf_q  <= res_ovf_d;
  end

  assign result_valid_o  = res_v_q;
  assign kept_value_o    = res_val_q;
  assign kept_position_o = res_pos_q;
  assign final_result_o  = res_fin_q;
  assign none_valid_o    = res_none_q;
  assign overflowed_o    = res_ovf_q;

  a_fin_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && final_result_o |=> !result_valid_o)
    else $error("word straight after final result");

  a_none_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && none_valid_o |-> final_result_o && (kept_value_o == '0))
    else $error("none-valid word not final or not zero");

  a_eol_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_list_i |=> busy_o)
    else $error("last word did not start processing");

  a_no_result_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !end_of_list_i |=> !result_valid_o)
    else $error("result during load");

endmodule

@@ tb/tb.sv @@
// Testbench for sigma_clip_outlier_filter_core: directed and random lists, with a
// scoreboard class predicting the kept words from its own sigma-clip calculation.
// Depends on scof_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import scof_pkg::*;

  class clip_scoreboard;
    logic [31:0] list_words[$];
    logic [15:0] clip_factor;
    bit          list_ovf;
    logic [40:0] kept_words[$];
    int          mismatches;
    int          words_checked;

    function new();
      clip_factor = CLIP_RESET;
      mismatches = 0;
      words_checked = 0;
    endfunction

    function automatic logic [63:0] dev_term(logic [31:0] v, logic signed [31:0] mean);
      logic signed [33:0] d;
      logic [33:0] m;
      logic [67:0] sq;
      d = $signed({{2{v[31]}}, v}) - $signed({{2{mean[31]}}, mean});
      m = d[33] ? -d : d;
      sq = m * m;
      return 64'(sq >> 6);
    endfunction

    function automatic bit passes_test(logic [63:0] term, int n, logic [63:0] total);
      logic [127:0] lhs, rhs;
      lhs = ({64'd0, term} * (n - 1)) << 32;
      rhs = {96'd0, clip_factor} * clip_factor * total;
      return lhs < rhs;
    endfunction

    function automatic void queue_word(logic [40:0] w);
      kept_words.insert(kept_words.size(), w);
    endfunction

    function automatic void note_word(logic [31:0] v, bit eol);
      int n, passes, cnt;
      logic signed [39:0] sum, num;
      logic signed [31:0] mean;
      logic [63:0] total;
      bit ovf;
      if (list_words.size() < MAX_ITEMS) list_words.insert(list_words.size(), v);
      else list_ovf = 1;
      if (!eol) return;
      n = list_words.size();
      ovf = list_ovf;
      if (n <= SMALL_LIST_LIMIT) begin
        for (int i = 0; i < n; i++)
          queue_word({list_words[i], 6'(i), i == n - 1, 1'b0, ovf});
      end else begin
        sum = 0;
        foreach (list_words[i]) sum += $signed(list_words[i]);
        num = 2 * sum + n;
        mean = (num >= 0) ? num / (2 * n) : -((-num + 2 * n - 1) / (2 * n));
        total = 0;
        foreach (list_words[i]) total += dev_term(list_words[i], mean);
        passes = 0;
        foreach (list_words[i]) passes += passes_test(dev_term(list_words[i], mean), n, total);
        if (passes == 0) queue_word({32'd0, 6'd0, 1'b1, 1'b1, ovf});
        else begin
          if (passes > RESULT_CAP) begin
            ovf = 1;
            passes = RESULT_CAP;
          end
          cnt = 0;
          foreach (list_words[i])
            if (cnt < passes && passes_test(dev_term(list_words[i], mean), n, total)) begin
              cnt++;
              queue_word({list_words[i], 6'(i), cnt == passes, 1'b0, ovf});
            end
        end
      end
      list_words.delete();
      list_ovf = 0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] exp, logic [63:0] got);
      $display("mismatch %s: expected %h got %h", what, exp, got);
      mismatches++;
    endtask

    task automatic check_word(logic [40:0] got);
      logic [40:0] exp;
      words_checked++;
      if (kept_words.size() == 0) begin
        report_mismatch("result with nothing expected", 0, got);
        return;
      end
      exp = kept_words.pop_front();
      if (got[40:9] !== exp[40:9]) report_mismatch("kept_value", exp[40:9], got[40:9]);
      if (got[8:3] !== exp[8:3]) report_mismatch("kept_position", exp[8:3], got[8:3]);
      if (got[2] !== exp[2]) report_mismatch("final_result", exp[2], got[2]);
      if (got[1] !== exp[1]) report_mismatch("none_valid", exp[1], got[1]);
      if (got[0] !== exp[0]) report_mismatch("overflowed", exp[0], got[0]);
    endtask
  endclass

  logic        clk_i = 0, rst_ni = 0, start_i = 0, end_of_list_i = 0;
  logic        cfg_valid_i = 0;
  logic [31:0] sample_value_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic        busy_o, cfg_ready_o, result_valid_o, final_result_o, none_valid_o, overflowed_o;
  logic [31:0] kept_value_o;
  logic [5:0]  kept_position_o;
  int          send_idle_pct;
  int          lists_sent;
  clip_scoreboard sb = new();

  sigma_clip_outlier_filter_core dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i)
    if (rst_ni && result_valid_o)
      sb.check_word({kept_value_o, kept_position_o, final_result_o, none_valid_o, overflowed_o});

  // start_i stays high between back-to-back words; callers drop it when done
  task automatic send_word(logic [31:0] v, bit eol);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 0;
      @(negedge clk_i);
    end
    start_i <= 1;
    sample_value_i <= v;
    end_of_list_i <= eol;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(v, eol);
    @(negedge clk_i);
    if (eol) lists_sent++;
  endtask

  task automatic write_clip(logic [15:0] k);
    start_i <= 0;
    while (sb.kept_words.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.clip_factor = k;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [31:0] rand_sample(int spread);
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2 * spread)) - spread);
    endcase
  endfunction

  task automatic send_list(int n, int spread);
    for (int i = 0; i < n; i++) send_word(rand_sample(spread), i == n - 1);
  endtask

  initial begin
    int n;
    send_idle_pct = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: small lists, extremes, zero spread, overflow, all-pass cap
    send_word(32'h7fffffff, 1);
    send_word(32'h80000000, 0); send_word(32'h00000000, 0); send_word(32'hffffffff, 1);
    for (int i = 0; i < 4; i++) send_word(32'h00010000, i == 3);
    send_word(32'h80000000, 0); send_word(32'h7fffffff, 0);
    send_word(32'h00000001, 0); send_word(32'h12345678, 0); send_word(32'h00000000, 1);
    write_clip(16'hffff);
    for (int i = 0; i < 66; i++) send_word(32'(i % 2), i == 65);
    for (int i = 0; i < 64; i++) send_word((i % 2) ? 32'h00010000 : 32'hffff0000, i == 63);
    write_clip(16'd0);
    send_list(5, 1000);
    write_clip(CLIP_RESET);
    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 84 : 0;
      for (int j = 0; j < 3; j++) begin
        n = $urandom_range(1, 8);
        send_list(n, $urandom_range(1) ? 300 : 1 << 30);
      end
      write_clip($urandom_range(3) == 0 ? 16'hffff : 16'($urandom()));
    end
    start_i <= 0;
    while (sb.kept_words.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("covered %0d lists, %0d result words, clip factor extremes and overflow",
             lists_sent, sb.words_checked);
    if (sb.mismatches == 0 && sb.kept_words.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
